### rtl/hra_pkg.sv
// Shared types and constants for the hysteresis rule actuator.
// Used by all RTL modules and the testbench; depends on nothing.
package hra_pkg;

	// Rule register store: eight registers of 38 bits on a 64-bit port
	localparam int RULE_REGS = 8;
	localparam int RULE_W    = 38;
	localparam int DATA_W    = 64;
	localparam int ADDR_W    = $clog2(RULE_REGS * 8);
	localparam int IDX_W     = $clog2(RULE_REGS);

	// Field widths that the register packing fixes
	localparam int LEVEL_W = 16;
	localparam int PWM_W   = 7;

	// Action codes
	localparam logic [1:0] ACT_RELAY_ONE = 2'd0;
	localparam logic [1:0] ACT_RELAY_TWO = 2'd1;
	localparam logic [1:0] ACT_PWM_FULL  = 2'd2;
	localparam logic [1:0] ACT_PWM_HALF  = 2'd3;

	// Duty levels
	localparam logic [PWM_W-1:0] PWM_OFF  = 7'd0;
	localparam logic [PWM_W-1:0] PWM_FULL = 7'd100;
	localparam logic [PWM_W-1:0] PWM_HALF = 7'd50;

	// One rule, in register bit order (MSB first)
	typedef struct packed {
		logic               enable;
		logic [1:0]         action;
		logic [2:0]         channel;
		logic [LEVEL_W-1:0] off_level;
		logic [LEVEL_W-1:0] threshold;
	} rule_t;

	// Actuator drive state
	typedef struct packed {
		logic             relay_one;
		logic             relay_two;
		logic [PWM_W-1:0] pwm;
	} act_state_t;

	// Outcome of one snapshot
	typedef struct packed {
		act_state_t drive;
		logic       fail;
	} eval_t;

endpackage

### rtl/hra_eval.sv
// Rule evaluation for one snapshot: comparator pairs per rule and a priority merge.
// Depends on hra_pkg.
module hra_eval #(
	parameter int NUM_CHANNELS = 8,
	parameter int VALUE_BITS   = 16,
	parameter int MAX_RULES    = 8
) (
	input  hra_pkg::rule_t                rules   [hra_pkg::RULE_REGS],
	input  logic signed [VALUE_BITS-1:0]  values  [NUM_CHANNELS],
	input  logic [NUM_CHANNELS-1:0]       present,
	input  hra_pkg::act_state_t           cur,
	output hra_pkg::eval_t                result
);

	localparam int CH_W  = $clog2(NUM_CHANNELS);
	localparam int CMP_W = (VALUE_BITS > hra_pkg::LEVEL_W) ? VALUE_BITS : hra_pkg::LEVEL_W;

	logic [MAX_RULES-1:0] hit;
	logic [MAX_RULES-1:0] drive;
	logic [MAX_RULES-1:0] turn_on;

	// Compare each rule's reading against its two levels
	for (genvar i = 0; i < MAX_RULES; i++) begin : g_rule
		logic [CH_W-1:0]   ch;
		logic              in_range;
		logic signed [CMP_W-1:0] val;
		logic signed [CMP_W-1:0] thr;
		logic signed [CMP_W-1:0] off;

		assign ch       = rules[i].channel[CH_W-1:0];
		assign in_range = (32'(rules[i].channel) < NUM_CHANNELS);
		assign hit[i]   = in_range && present[ch];
		assign val      = CMP_W'(values[ch]);
		assign thr      = CMP_W'(signed'(rules[i].threshold));
		assign off      = CMP_W'(signed'(rules[i].off_level));
		assign turn_on[i] = (val > thr);
		assign drive[i]   = (val > thr) || (val < off);
	end

	// Apply rules in order; the later rule wins, a missing channel forces all off
	always_comb begin
		result.drive = cur;
		result.fail  = 1'b0;
		for (int i = 0; i < MAX_RULES; i++) begin
			if (rules[i].enable) begin
				if (!hit[i]) begin
					result.fail = 1'b1;
				end else if (drive[i]) begin
					unique case (rules[i].action)
						hra_pkg::ACT_RELAY_ONE: result.drive.relay_one = turn_on[i];
						hra_pkg::ACT_RELAY_TWO: result.drive.relay_two = turn_on[i];
						hra_pkg::ACT_PWM_FULL: begin
							result.drive.pwm = turn_on[i] ? hra_pkg::PWM_FULL : hra_pkg::PWM_OFF;
						end
						hra_pkg::ACT_PWM_HALF: begin
							result.drive.pwm = turn_on[i] ? hra_pkg::PWM_HALF : hra_pkg::PWM_OFF;
						end
						default: result.drive = result.drive;
					endcase
				end
			end
		end
		if (result.fail) begin
			result.drive.relay_one = 1'b0;
			result.drive.relay_two = 1'b0;
			result.drive.pwm       = hra_pkg::PWM_OFF;
		end
	end

endmodule

### rtl/hysteresis_rule_actuator_top.sv
// Hysteresis rule actuator: one sensor snapshot in, one actuator result out per beat.
// Throughput is one beat per cycle unless res_ready holds the result; a snapshot passes
// the input register, then the result register. Rule evaluation is combinational and
// feeds the state update directly, since each snapshot starts from the drive state the
// previous one left. The result register doubles as the held drive state. Rule
// registers sit on an APB port at byte address 8*i; the user must write them only while
// the block is idle, which the block does not enforce. Depends on hra_pkg and hra_eval.
module hysteresis_rule_actuator_top #(
	parameter int NUM_CHANNELS = 8,
	parameter int VALUE_BITS   = 16,
	parameter int MAX_RULES    = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hra_pkg::ADDR_W-1:0]    paddr,
	input  logic [hra_pkg::DATA_W-1:0]    pwdata,
	output logic [hra_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// snapshot channel
	input  logic                          snap_valid,
	output logic                          snap_ready,
	input  logic signed [VALUE_BITS-1:0]  value_0,
	input  logic signed [VALUE_BITS-1:0]  value_1,
	input  logic signed [VALUE_BITS-1:0]  value_2,
	input  logic signed [VALUE_BITS-1:0]  value_3,
	input  logic signed [VALUE_BITS-1:0]  value_4,
	input  logic signed [VALUE_BITS-1:0]  value_5,
	input  logic signed [VALUE_BITS-1:0]  value_6,
	input  logic signed [VALUE_BITS-1:0]  value_7,
	input  logic [7:0]                    present_mask,
	// result channel
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          relay_one,
	output logic                          relay_two,
	output logic [hra_pkg::PWM_W-1:0]     pwm_percent,
	output logic                          failsafe_alarm,
	output logic [2:0]                    changed_mask
);

	hra_pkg::rule_t              rule_q [hra_pkg::RULE_REGS];
	logic [hra_pkg::IDX_W-1:0]   cfg_idx;
	logic                        cfg_wr;

	logic signed [VALUE_BITS-1:0] value_in [8];
	logic signed [VALUE_BITS-1:0] value_s1 [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]      present_s1;
	logic                         valid_s1;
	logic                         advance;

	hra_pkg::act_state_t          state_q;
	logic                         fail_q;
	logic [2:0]                   changed_q;
	logic                         res_valid_q;
	hra_pkg::eval_t               eval_res;

	// Configuration access
	assign pready  = 1'b1;
	assign cfg_idx = paddr[hra_pkg::ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = hra_pkg::DATA_W'(rule_q[cfg_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hra_pkg::RULE_REGS; i++) begin
				rule_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			rule_q[cfg_idx] <= hra_pkg::rule_t'(pwdata[hra_pkg::RULE_W-1:0]);
		end
	end

	// Handshake: advance when the result register is free or being drained
	assign advance    = valid_s1 && (!res_valid_q || res_ready);
	assign snap_ready = !valid_s1 || advance;

	assign value_in[0] = value_0;
	assign value_in[1] = value_1;
	assign value_in[2] = value_2;
	assign value_in[3] = value_3;
	assign value_in[4] = value_4;
	assign value_in[5] = value_5;
	assign value_in[6] = value_6;
	assign value_in[7] = value_7;

	// Input register: hold the snapshot for evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (snap_ready) begin
			valid_s1 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				value_s1[c] <= value_in[c];
			end
			present_s1 <= present_mask[NUM_CHANNELS-1:0];
		end
	end

	hra_eval #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.VALUE_BITS   (VALUE_BITS),
		.MAX_RULES    (MAX_RULES)
	) u_eval (
		.rules   (rule_q),
		.values  (value_s1),
		.present (present_s1),
		.cur     (state_q),
		.result  (eval_res)
	);

	// Result register and held drive state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			state_q     <= '0;
			fail_q      <= 1'b0;
			changed_q   <= '0;
		end else begin
			if (advance) begin
				res_valid_q <= 1'b1;
				state_q     <= eval_res.drive;
				fail_q      <= eval_res.fail;
				changed_q   <= {eval_res.drive.pwm != state_q.pwm,
				                eval_res.drive.relay_two != state_q.relay_two,
				                eval_res.drive.relay_one != state_q.relay_one};
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid      = res_valid_q;
	assign relay_one      = state_q.relay_one;
	assign relay_two      = state_q.relay_two;
	assign pwm_percent    = state_q.pwm;
	assign failsafe_alarm = fail_q;
	assign changed_mask   = changed_q;

endmodule

### rtl/hra_checker.sv
// Port-level checks for the hysteresis rule actuator, bound to the top level.
// Depends on hra_pkg for the duty levels.
module hra_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      snap_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic                      relay_one,
	input logic                      relay_two,
	input logic [hra_pkg::PWM_W-1:0] pwm_percent,
	input logic                      failsafe_alarm,
	input logic [2:0]                changed_mask
);

	// Failsafe beat drives every output off
	a_failsafe_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && failsafe_alarm |-> !relay_one && !relay_two &&
		pwm_percent == hra_pkg::PWM_OFF)
		else $error("failsafe beat with an output still driven");

	// Duty takes only the three legal levels
	a_pwm_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pwm_percent == hra_pkg::PWM_OFF ||
		pwm_percent == hra_pkg::PWM_HALF || pwm_percent == hra_pkg::PWM_FULL)
		else $error("illegal pwm level");

	// With no result waiting the block must take a snapshot
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> snap_ready)
		else $error("snapshot stalled with empty result register");

	// A stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(relay_one) &&
		$stable(relay_two) && $stable(pwm_percent) && $stable(failsafe_alarm) &&
		$stable(changed_mask))
		else $error("stalled result changed");

endmodule

bind hysteresis_rule_actuator_top hra_checker u_hra_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.snap_ready     (snap_ready),
	.res_valid      (res_valid),
	.res_ready      (res_ready),
	.relay_one      (relay_one),
	.relay_two      (relay_two),
	.pwm_percent    (pwm_percent),
	.failsafe_alarm (failsafe_alarm),
	.changed_mask   (changed_mask)
);

### dv/hysteresis_rule_actuator_top_test.sv
// Self-checking testbench for hysteresis_rule_actuator_top: rule registers over APB,
// snapshot beats in, drive results checked against a cycle-free predictor.
// Depends on hra_pkg and the actuator RTL; needs no other file.

localparam int SNAP_CHANNELS = 8;
localparam int SNAP_BITS     = 16;
localparam int EVAL_RULES    = 8;

// One sensor snapshot as offered to the block
typedef struct packed {
	logic [SNAP_CHANNELS-1:0][SNAP_BITS-1:0] value;
	logic [7:0]                              present;
} snapshot_t;

// One actuator result as seen on the result channel
typedef struct packed {
	logic                      relay_one;
	logic                      relay_two;
	logic [hra_pkg::PWM_W-1:0] pwm;
	logic                      failsafe;
	logic [2:0]                changed;
} drive_result_t;

// Tracks the rule store and the held drive state, and queues the drive each snapshot should give
class drive_tracker;
	hra_pkg::rule_t     rules [hra_pkg::RULE_REGS];
	hra_pkg::act_state_t held;
	drive_result_t      expected_drive [$];
	int n_snapshots, n_checked, n_failsafe, n_changed, n_errors;

	function new();
		foreach (rules[i]) rules[i] = '0;
		held = '0;
		n_snapshots = 0;
		n_checked = 0;
		n_failsafe = 0;
		n_changed = 0;
		n_errors = 0;
	endfunction

	function void set_rule(int idx, hra_pkg::rule_t r);
		rules[idx] = r;
	endfunction

	function int outstanding();
		return expected_drive.size();
	endfunction

	// Walk the rules in order from the held state; a later rule overrides an earlier one
	function void note_snapshot(snapshot_t s);
		hra_pkg::act_state_t nxt;
		hra_pkg::rule_t r;
		drive_result_t res;
		logic signed [SNAP_BITS-1:0] reading;
		logic drive_on, fires, missing;
		nxt = held;
		missing = 1'b0;
		drive_on = 1'b0;
		for (int i = 0; i < EVAL_RULES; i++) begin
			r = rules[i];
			if (!r.enable)
				continue;
			if (int'(r.channel) >= SNAP_CHANNELS || !s.present[r.channel]) begin
				missing = 1'b1;
				continue;
			end
			reading = s.value[r.channel];
			fires = 1'b1;
			// above threshold is tested first, so it wins when threshold sits below off level
			if (reading > $signed(r.threshold))
				drive_on = 1'b1;
			else if (reading < $signed(r.off_level))
				drive_on = 1'b0;
			else
				fires = 1'b0;
			if (!fires)
				continue;
			case (r.action)
				hra_pkg::ACT_RELAY_ONE: nxt.relay_one = drive_on;
				hra_pkg::ACT_RELAY_TWO: nxt.relay_two = drive_on;
				hra_pkg::ACT_PWM_FULL:  nxt.pwm = drive_on ? hra_pkg::PWM_FULL : hra_pkg::PWM_OFF;
				default:                nxt.pwm = drive_on ? hra_pkg::PWM_HALF : hra_pkg::PWM_OFF;
			endcase
		end
		// failsafe drops every output
		if (missing) begin
			nxt.relay_one = 1'b0;
			nxt.relay_two = 1'b0;
			nxt.pwm = hra_pkg::PWM_OFF;
		end
		res.relay_one = nxt.relay_one;
		res.relay_two = nxt.relay_two;
		res.pwm = nxt.pwm;
		res.failsafe = missing;
		res.changed = {nxt.pwm != held.pwm, nxt.relay_two != held.relay_two,
			nxt.relay_one != held.relay_one};
		held = nxt;
		expected_drive.push_back(res);
		n_snapshots++;
	endfunction

	function void compare_field(string name, logic [6:0] want, logic [6:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			n_errors++;
		end
	endfunction

	function void check_drive(drive_result_t got);
		drive_result_t want;
		if (expected_drive.size() == 0) begin
			$error("result beat with no snapshot outstanding");
			n_errors++;
			return;
		end
		want = expected_drive.pop_front();
		compare_field("relay_one", 7'(want.relay_one), 7'(got.relay_one));
		compare_field("relay_two", 7'(want.relay_two), 7'(got.relay_two));
		compare_field("pwm_percent", want.pwm, got.pwm);
		compare_field("failsafe_alarm", 7'(want.failsafe), 7'(got.failsafe));
		compare_field("changed_mask", 7'(want.changed), 7'(got.changed));
		n_checked++;
		if (want.failsafe)
			n_failsafe++;
		if (want.changed != 3'd0)
			n_changed++;
	endfunction
endclass

module hysteresis_rule_actuator_top_test;

	localparam int LONG_STALL     = 80;
	localparam int SETTLE_CYCLES  = 6;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [hra_pkg::ADDR_W-1:0] paddr = '0;
	logic [hra_pkg::DATA_W-1:0] pwdata = '0;
	logic [hra_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic snap_valid = 1'b0;
	logic snap_ready;
	logic signed [SNAP_BITS-1:0] value_0 = '0, value_1 = '0, value_2 = '0, value_3 = '0;
	logic signed [SNAP_BITS-1:0] value_4 = '0, value_5 = '0, value_6 = '0, value_7 = '0;
	logic [7:0] present_mask = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic relay_one, relay_two, failsafe_alarm;
	logic [hra_pkg::PWM_W-1:0] pwm_percent;
	logic [2:0] changed_mask;

	drive_tracker book;
	hra_pkg::rule_t cur_rules [hra_pkg::RULE_REGS];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_asked = 0;
	int stall_taken = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	hysteresis_rule_actuator_top #(
		.NUM_CHANNELS(SNAP_CHANNELS),
		.VALUE_BITS(SNAP_BITS),
		.MAX_RULES(EVAL_RULES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready),
		.value_0(value_0),
		.value_1(value_1),
		.value_2(value_2),
		.value_3(value_3),
		.value_4(value_4),
		.value_5(value_5),
		.value_6(value_6),
		.value_7(value_7),
		.present_mask(present_mask),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.relay_one(relay_one),
		.relay_two(relay_two),
		.pwm_percent(pwm_percent),
		.failsafe_alarm(failsafe_alarm),
		.changed_mask(changed_mask)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: random back-pressure, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_taken != stall_asked) begin
			res_ready <= 1'b0;
			stall_left <= LONG_STALL;
			stall_taken <= stall_taken + 1;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Check each result beat against the oldest expected drive
	always @(posedge clk) begin
		drive_result_t got;
		if (arst_n && res_valid && res_ready) begin
			got.relay_one = relay_one;
			got.relay_two = relay_two;
			got.pwm = pwm_percent;
			got.failsafe = failsafe_alarm;
			got.changed = changed_mask;
			book.check_drive(got);
		end
	end

	// Give up when no beat moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (snap_valid && snap_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("hysteresis_rule_actuator_top verification failed");
				$finish;
			end
		end
	end

	task automatic apb_write(input int idx, input logic [hra_pkg::DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= hra_pkg::ADDR_W'(idx * 8);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// leave the bus idle before the next transfer
		@(posedge clk);
	endtask

	// Junk above bit 37 must be dropped by the register
	task automatic set_rule(input int idx, input hra_pkg::rule_t r);
		apb_write(idx, {26'($urandom), r});
		book.set_rule(idx, r);
		cur_rules[idx] = r;
	endtask

	task automatic offer_snapshot(input snapshot_t s);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			snap_valid <= 1'b0;
			@(posedge clk);
		end
		snap_valid <= 1'b1;
		value_0 <= s.value[0];
		value_1 <= s.value[1];
		value_2 <= s.value[2];
		value_3 <= s.value[3];
		value_4 <= s.value[4];
		value_5 <= s.value[5];
		value_6 <= s.value[6];
		value_7 <= s.value[7];
		present_mask <= s.present;
		@(posedge clk);
		while (!snap_ready) @(posedge clk);
		book.note_snapshot(s);
	endtask

	// Hold the input until every expected drive has come back, then let the pipe settle
	task automatic drain();
		snap_valid <= 1'b0;
		while (book.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic hra_pkg::rule_t make_rule(logic en, logic [1:0] act, int ch, int thr,
			int off);
		hra_pkg::rule_t r;
		r.enable = en;
		r.action = act;
		r.channel = 3'(ch);
		r.threshold = 16'(thr);
		r.off_level = 16'(off);
		return r;
	endfunction

	function automatic snapshot_t make_snap(int v0, int v1, int v2, int v3, int v4, int v5,
			int v6, int v7, logic [7:0] mask);
		snapshot_t s;
		s.value = {16'(v7), 16'(v6), 16'(v5), 16'(v4), 16'(v3), 16'(v2), 16'(v1), 16'(v0)};
		s.present = mask;
		return s;
	endfunction

	// Mostly a sane hysteresis band around a random centre; now and then raw bits
	function automatic hra_pkg::rule_t random_rule();
		hra_pkg::rule_t r;
		logic [15:0] centre, band;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		r = raw[hra_pkg::RULE_W-1:0];
		if ($urandom_range(0, 9) != 0) begin
			centre = 16'($urandom);
			band = 16'($urandom_range(0, 400));
			r.threshold = centre + band;
			r.off_level = centre - band;
			if ($urandom_range(0, 7) == 0) begin
				r.threshold = centre - band;
				r.off_level = centre + band;
			end
			r.enable = ($urandom_range(0, 5) != 0);
		end
		return r;
	endfunction

	// Steer readings onto and around the live levels so the held band gets exercised
	function automatic snapshot_t random_snapshot();
		snapshot_t s;
		logic [15:0] level;
		int pick;
		for (int c = 0; c < SNAP_CHANNELS; c++) begin
			pick = $urandom_range(0, 15);
			s.value[c] = (pick == 0) ? 16'h7FFF : (pick == 1) ? 16'h8000 : 16'($urandom);
		end
		for (int k = 0; k < hra_pkg::RULE_REGS; k++) begin
			if (cur_rules[k].enable && $urandom_range(0, 1) == 1) begin
				level = $urandom_range(0, 1) ? cur_rules[k].threshold : cur_rules[k].off_level;
				s.value[cur_rules[k].channel] = level + 16'($urandom_range(0, 4)) - 16'd2;
			end
		end
		s.present = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'hFF;
		return s;
	endfunction

	task automatic run_phase(input int items, input int s_idle, input int r_idle,
			input bit hold_off, input bit midway_pause);
		drain();
		for (int k = 0; k < hra_pkg::RULE_REGS; k++)
			set_rule(k, random_rule());
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		if (hold_off)
			stall_asked++;
		for (int n = 0; n < items; n++) begin
			if (midway_pause && n == items / 2)
				drain();
			offer_snapshot(random_snapshot());
		end
	endtask

	initial begin
		book = new();
		foreach (cur_rules[i]) cur_rules[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No rule enabled after reset: state held, no alarm
		offer_snapshot(make_snap(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 8'hFF));
		offer_snapshot(make_snap(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768, 8'h00));
		drain();

		// One rule per action, an inverted band, a disabled rule, a band that never fires
		set_rule(0, make_rule(1'b1, hra_pkg::ACT_RELAY_ONE, 0, 100, -100));
		set_rule(1, make_rule(1'b1, hra_pkg::ACT_RELAY_TWO, 1, 0, -16));
		set_rule(2, make_rule(1'b1, hra_pkg::ACT_PWM_FULL, 2, 50, 10));
		set_rule(3, make_rule(1'b1, hra_pkg::ACT_PWM_HALF, 3, 80, 20));
		set_rule(4, make_rule(1'b1, hra_pkg::ACT_RELAY_TWO, 4, -100, 100));
		set_rule(5, make_rule(1'b0, hra_pkg::ACT_RELAY_ONE, 5, 0, 0));
		set_rule(6, make_rule(1'b1, hra_pkg::ACT_RELAY_ONE, 6, 32767, -32768));
		set_rule(7, make_rule(1'b1, hra_pkg::ACT_PWM_FULL, 7, 200, 100));
		offer_snapshot(make_snap(101, 1, 51, 81, 0, 0, 0, 201, 8'hFF));
		offer_snapshot(make_snap(100, 0, 50, 80, -100, 0, 32767, 200, 8'hFF));
		offer_snapshot(make_snap(-100, -16, 10, 20, 100, 0, -32768, 100, 8'hFF));
		offer_snapshot(make_snap(-101, -17, 9, 19, 0, 0, 0, 99, 8'hFF));
		offer_snapshot(make_snap(0, 0, 60, 90, 0, 0, 0, 150, 8'hFF));
		offer_snapshot(make_snap(0, 0, 60, 90, 0, 0, 0, 150, 8'hDF));
		offer_snapshot(make_snap(0, 0, 60, 90, 0, 0, 0, 150, 8'hFE));
		offer_snapshot(make_snap(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 8'hFF));
		offer_snapshot(make_snap(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
			-32768, 8'hFF));
		offer_snapshot(make_snap(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 8'h7F));
		drain();

		// Every register at all ones: eight identical rules on channel seven
		for (int k = 0; k < hra_pkg::RULE_REGS; k++)
			set_rule(k, hra_pkg::rule_t'({hra_pkg::RULE_W{1'b1}}));
		offer_snapshot(make_snap(0, 0, 0, 0, 0, 0, 0, 0, 8'hFF));
		offer_snapshot(make_snap(0, 0, 0, 0, 0, 0, 0, -1, 8'hFF));
		offer_snapshot(make_snap(0, 0, 0, 0, 0, 0, 0, -2, 8'hFF));
		offer_snapshot(make_snap(0, 0, 0, 0, 0, 0, 0, 32767, 8'h7F));
		drain();

		// Everything set but the enable bit, then everything cleared
		for (int k = 0; k < hra_pkg::RULE_REGS; k++)
			set_rule(k, hra_pkg::rule_t'({1'b0, {(hra_pkg::RULE_W - 1){1'b1}}}));
		offer_snapshot(make_snap(0, 0, 0, 0, 0, 0, 0, 0, 8'hFF));
		offer_snapshot(make_snap(0, 0, 0, 0, 0, 0, 0, 0, 8'h00));
		drain();
		for (int k = 0; k < hra_pkg::RULE_REGS; k++)
			set_rule(k, '0);
		offer_snapshot(random_snapshot());

		// Random rule sets under receiver idling, sender idling, then full rate
		run_phase(150, 22, 66, 1'b0, 1'b0);
		run_phase(150, 22, 66, 1'b0, 1'b1);
		run_phase(150, 66, 22, 1'b0, 1'b0);
		run_phase(150, 66, 22, 1'b0, 1'b0);
		run_phase(150, 0, 0, 1'b1, 1'b0);
		run_phase(150, 0, 0, 1'b0, 1'b1);
		drain();

		$display("Covered %0d snapshots over directed and random rule sets; %0d results checked",
			book.n_snapshots, book.n_checked);
		$display("Failsafe raised on %0d results, outputs changed on %0d, %0d mismatches",
			book.n_failsafe, book.n_changed, book.n_errors);
		if (book.n_errors == 0 && book.outstanding() == 0)
			$display("hysteresis_rule_actuator_top verification clean");
		else
			$display("hysteresis_rule_actuator_top verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/hra_pkg.sv
rtl/hra_eval.sv
rtl/hysteresis_rule_actuator_top.sv
rtl/hra_checker.sv
dv/hysteresis_rule_actuator_top_test.sv
